// File: rtl/fscl_pkg.sv
// fscl_pkg: shared types and constants for the frequency-sorted candidate list.
// Holds the input/result word structs, entry layout, memory request struct and codes.
// No dependencies.
`default_nettype none
package fscl_pkg;

    localparam int CAPACITY = 2048;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ACT_SORTED = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_READ_OK   = 3'd3,
        ST_READ_OOR  = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [15:0] char_code;
        logic [30:0] frequency;
        logic [10:0] read_index;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [11:0] position;
        logic [15:0] code_out;
        logic [30:0] freq_out;
        logic [11:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic [15:0] code;
        logic [30:0] freq;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_SCAN,
        S_READ
    } t_state;

endpackage
`default_nettype wire

// File: rtl/fscl_mem.sv
// fscl_mem: entry store, one write port and one read port, registered read data.
// Depends on fscl_pkg for the entry layout and request struct.
`default_nettype none
module fscl_mem
    import fscl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_entry        o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/fscl_ctrl.sv
// fscl_ctrl: sequencer for insert, append scan, read and clear; owns the fill count.
// Depends on fscl_pkg; drives the fscl_mem request and consumes its read data.
`default_nettype none
module fscl_ctrl
    import fscl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_word i_item,
    input  wire t_entry   i_rdata,
    output t_mem_req      o_req,
    output logic          o_busy,
    output logic          o_done,
    output t_out_word     o_result
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_fill, n_fill;
    t_in_word         r_item, n_item;
    logic             r_done, n_done;
    t_out_word        r_res, n_res;
    t_mem_req         req;
    t_entry           new_entry;
    logic [CNT_W-1:0] fill_inc;

    function automatic t_out_word mk_res(t_status st, logic [11:0] pos,
                                         logic [11:0] cnt);
        t_out_word w;
        w.status      = st;
        w.position    = pos;
        w.code_out    = '0;
        w.freq_out    = '0;
        w.entry_count = cnt;
        return w;
    endfunction

    assign fill_inc = r_fill + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_item <= n_item;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_item    = r_item;
        n_done    = 1'b0;
        n_res     = r_res;
        req       = '0;
        new_entry = '{code: r_item.char_code, freq: r_item.frequency};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item    = i_item;
                    new_entry = '{code: i_item.char_code, freq: i_item.frequency};
                    case (i_item.action)
                        ACT_SORTED, ACT_APPEND: begin
                            if (r_fill == CNT_W'(CAPACITY)) begin
                                n_done = 1'b1;
                                n_res  = mk_res(ST_FULL, '0, 12'(r_fill));
                            end else if (r_fill == '0) begin
                                req.we    = 1'b1;
                                req.waddr = '0;
                                req.wdata = new_entry;
                                n_fill    = fill_inc;
                                n_done    = 1'b1;
                                n_res     = mk_res(ST_STORED, '0, 12'(fill_inc));
                            end else if (i_item.action == ACT_SORTED) begin
                                // walk down from the tail, one entry per cycle
                                req.raddr = r_fill[IDX_W-1:0] - IDX_W'(1);
                                n_idx     = r_fill[IDX_W-1:0];
                                n_state   = S_SHIFT;
                            end else begin
                                req.raddr = '0;
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        ACT_READ: begin
                            if (CNT_W'(i_item.read_index) < r_fill) begin
                                req.raddr = i_item.read_index[IDX_W-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_done = 1'b1;
                                n_res  = mk_res(ST_READ_OOR, 12'(i_item.read_index),
                                                12'(r_fill));
                            end
                        end
                        ACT_CLEAR: begin
                            n_fill = '0;
                            n_done = 1'b1;
                            n_res  = mk_res(ST_CLEARED, '0, '0);
                        end
                        default: begin
                            n_done = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // i_rdata holds entry r_idx-1
                if (i_rdata.freq < r_item.frequency) begin
                    req.we    = 1'b1;
                    req.waddr = r_idx;
                    req.wdata = i_rdata;
                    n_idx     = r_idx - IDX_W'(1);
                    if (r_idx == IDX_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        req.raddr = r_idx - IDX_W'(2);
                    end
                end else begin
                    req.we    = 1'b1;
                    req.waddr = r_idx;
                    req.wdata = new_entry;
                    n_fill    = fill_inc;
                    n_done    = 1'b1;
                    n_res     = mk_res(ST_STORED, 12'(r_idx), 12'(fill_inc));
                    n_state   = S_IDLE;
                end
            end
            S_PLACE: begin
                req.we    = 1'b1;
                req.waddr = r_idx;
                req.wdata = new_entry;
                n_fill    = fill_inc;
                n_done    = 1'b1;
                n_res     = mk_res(ST_STORED, 12'(r_idx), 12'(fill_inc));
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                // i_rdata holds entry r_idx
                if (i_rdata.code == r_item.char_code) begin
                    n_done  = 1'b1;
                    n_res   = mk_res(ST_DUPLICATE, 12'(r_idx), 12'(r_fill));
                    n_state = S_IDLE;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_fill) begin
                    req.we    = 1'b1;
                    req.waddr = r_fill[IDX_W-1:0];
                    req.wdata = new_entry;
                    n_fill    = fill_inc;
                    n_done    = 1'b1;
                    n_res     = mk_res(ST_STORED, 12'(r_fill), 12'(fill_inc));
                    n_state   = S_IDLE;
                end else begin
                    req.raddr = r_idx + IDX_W'(1);
                    n_idx     = r_idx + IDX_W'(1);
                end
            end
            S_READ: begin
                n_done           = 1'b1;
                n_res            = mk_res(ST_READ_OK, 12'(r_item.read_index),
                                          12'(r_fill));
                n_res.code_out   = i_rdata.code;
                n_res.freq_out   = i_rdata.freq;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req    = req;
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// File: rtl/freq_sorted_candidate_list.sv
// freq_sorted_candidate_list: bounded list of codes; sorted insert or append.
// Depends on fscl_pkg, fscl_mem and fscl_ctrl.
//
//   channel | ports                      | handshake
//   --------+----------------------------+---------------------------------
//   command | start, i_item (t_in_word)  | word taken when start & !busy
//   result  | o_done, o_result           | o_done high one cycle per word
//
// Clear, rejected insert, out-of-range read and an insert into an empty list
// finish in S_IDLE; a read waits in S_READ for registered read data. A sorted
// insert shifts entries toward the tail in S_SHIFT and puts the code after
// entries of equal or higher frequency; an append scans for a duplicate code,
// one entry per cycle through the single read port of the entry memory.
// Reset clears the sequencer and the fill count only; no memory sweep.
// Results cannot be stalled: each appears in the cycle after its word finishes.
`default_nettype none
module freq_sorted_candidate_list
    import fscl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_word i_item,
    output logic          busy,
    output logic          o_done,
    output t_out_word     o_result
);

    t_mem_req mem_req;
    t_entry   mem_rdata;

    fscl_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    fscl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_rdata  (mem_rdata),
        .o_req    (mem_req),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
